/* rtl/ir_pulse_frame_decoder_top_assert.svh */
// ----------------------------------------------------------------------------
// IR pulse frame decoder assertion macros
// Concurrent assertion shorthands clocked on clk; all but the last are held off by rst_n.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_FRAME_DECODER_TOP_ASSERT_SVH
`define IR_PULSE_FRAME_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define IRPFD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irpfd assertion failed");

// Next-cycle implication, off while in reset.
`define IRPFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irpfd assertion failed");

// Next-cycle implication that also holds through reset.
`define IRPFD_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("irpfd assertion failed");

`endif

/* rtl/irpfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse frame decoder package
// Timing constants, key code table and result layout.
// ----------------------------------------------------------------------------
package irpfd_pkg;

  localparam int DUR_W  = 16;
  localparam int TOL_W  = 12;
  localparam int CODE_W = 32;
  localparam int CNT_W  = 6;
  localparam int KEY_W  = 5;

  localparam logic [DUR_W-1:0] HDR_LOW_US   = 16'd9000;
  localparam logic [DUR_W-1:0] HDR_HIGH_US  = 16'd4500;
  localparam logic [DUR_W-1:0] SKIP_US      = 16'd550;
  localparam int               ONE_US       = 600;
  localparam int               ZERO_US      = 1600;
  localparam logic [DUR_W-1:0] BIT_SPLIT_US = DUR_W'((ONE_US + ZERO_US) / 2);

  localparam logic [TOL_W-1:0] TOL_RESET = 12'd200;
  localparam logic [DUR_W-1:0] GAP_RESET = 16'd30000;

  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_END_GAP   = 1'b1;

  localparam int               KEY_COUNT   = 17;
  localparam logic [KEY_W-1:0] KEY_UNKNOWN = 5'd17;

  localparam logic [CODE_W-1:0] KEY_CODES [KEY_COUNT] = '{
    32'h45ba00ff, 32'h46b900ff, 32'h47b800ff, 32'h44bb00ff, 32'h40bf00ff,
    32'h43bc00ff, 32'h07f800ff, 32'h15ea00ff, 32'h09f600ff, 32'h16e900ff,
    32'h19e600ff, 32'h0df200ff, 32'h18e700ff, 32'h08f700ff, 32'h1ce300ff,
    32'h5aa500ff, 32'h52ad00ff
  };

  typedef struct packed {
    logic [KEY_W-1:0]  key_index;
    logic              skip_error;
    logic [CNT_W-1:0]  bit_count;
    logic [CODE_W-1:0] code_word;
  } result_t;

  function automatic logic near_nominal(input logic [DUR_W-1:0] d,
                                        input logic [DUR_W-1:0] nom,
                                        input logic [TOL_W-1:0] tol);
    logic [DUR_W-1:0] diff;
    diff = (d >= nom) ? (d - nom) : (nom - d);
    return diff <= DUR_W'(tol);
  endfunction

  function automatic logic [KEY_W-1:0] key_lookup(input logic [CODE_W-1:0] code);
    logic [KEY_W-1:0] idx;
    idx = KEY_UNKNOWN;
    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
      if (KEY_CODES[i] == code) begin
        idx = KEY_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* rtl/ir_pulse_frame_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse frame decoder
// Decodes NEC-style infrared frames from a stream of measured pulses.
//
//   channel | direction | handshake          | content
//   in_     | slave     | tvalid/tready      | pulse level and duration
//   out_    | master    | tvalid/tready      | one result per ended frame
//   cfg_    | APB slave | psel/penable/pready| tolerance, end gap
//
// One pulse per cycle unless a frame end is stalled: a pulse waits in the
// input register, its state update and result are formed from it and land
// in the output register, which then raises out_tvalid for a frame result.
// Synchronous active-low reset clears decode state and loads register defaults.
// A full output register stalls only pulses that end a frame.
// ----------------------------------------------------------------------------
module ir_pulse_frame_decoder_top
  import irpfd_pkg::*;
#(
  parameter int MAX_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // [15:0] duration_us
  input  logic        in_tuser,      // [0] level
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,     // [31:0] code_word, [37:32] bit_count,
                                     // [38] skip_error, [43:39] key_index, [47:44] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int ACC_CNT_W = $clog2(MAX_BITS + 1);
  localparam int IDX_W     = $clog2(MAX_BITS);

  logic [TOL_W-1:0] tol_r;
  logic [DUR_W-1:0] gap_r;

  logic             s_valid_r;
  logic             s_lvl_r;
  logic [DUR_W-1:0] s_dur_r;
  logic             s_adv;
  logic             s_emit;

  logic                 in_frame_r, in_frame_nxt;
  logic                 prev_lvl_r, prev_lvl_nxt;
  logic [DUR_W-1:0]     prev_dur_r, prev_dur_nxt;
  logic                 expect_r, expect_nxt;
  logic [MAX_BITS-1:0]  accum_r, accum_nxt;
  logic [ACC_CNT_W-1:0] bits_r, bits_nxt;
  logic                 err_r, err_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic                 pend_bit_r, pend_bit_nxt;
  logic                 pend_err_r, pend_err_nxt;

  logic                 commit_ok;
  logic [MAX_BITS-1:0]  acc_commit;
  logic [ACC_CNT_W-1:0] bits_commit;
  logic                 err_commit;
  logic [MAX_BITS-1:0]  fin_word;

  logic    out_valid_r;
  result_t result_r, result_nxt;

  // Configuration port
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
      gap_r <= GAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        REG_TOLERANCE: tol_r <= cfg_pwdata[TOL_W-1:0];
        REG_END_GAP:   gap_r <= cfg_pwdata[DUR_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_TOLERANCE: cfg_prdata = 32'(tol_r);
      REG_END_GAP:   cfg_prdata = 32'(gap_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Input register
  assign s_emit    = s_valid_r && in_frame_r && (s_dur_r > gap_r);
  assign s_adv     = s_valid_r && (!s_emit || !out_valid_r || out_tready);
  assign in_tready = !s_valid_r || s_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tready) begin
      s_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s_lvl_r <= in_tuser;
      s_dur_r <= in_tdata[DUR_W-1:0];
    end
  end

  // Pulse decode
  always_comb begin
    commit_ok  = pend_valid_r && (bits_r < ACC_CNT_W'(MAX_BITS));
    acc_commit = accum_r;
    for (int i = 0; i < MAX_BITS; i++) begin
      if (commit_ok && (IDX_W'(i) == bits_r[IDX_W-1:0])) begin
        acc_commit[i] = pend_bit_r;
      end
    end
    bits_commit = bits_r + ACC_CNT_W'(commit_ok);
    err_commit  = err_r | (commit_ok & pend_err_r);
    fin_word    = s_lvl_r ? acc_commit : accum_r;

    result_nxt.code_word  = CODE_W'(fin_word);
    result_nxt.bit_count  = CNT_W'(s_lvl_r ? bits_commit : bits_r);
    result_nxt.skip_error = s_lvl_r ? err_commit : err_r;
    result_nxt.key_index  = key_lookup(CODE_W'(fin_word));

    in_frame_nxt   = in_frame_r;
    expect_nxt     = expect_r;
    accum_nxt      = accum_r;
    bits_nxt       = bits_r;
    err_nxt        = err_r;
    pend_valid_nxt = pend_valid_r;
    pend_bit_nxt   = pend_bit_r;
    pend_err_nxt   = pend_err_r;
    prev_lvl_nxt   = s_lvl_r;
    prev_dur_nxt   = s_dur_r;

    if (!in_frame_r) begin
      if (!prev_lvl_r && s_lvl_r && near_nominal(prev_dur_r, HDR_LOW_US, tol_r)
          && near_nominal(s_dur_r, HDR_HIGH_US, tol_r)) begin
        in_frame_nxt   = 1'b1;
        expect_nxt     = 1'b0;
        accum_nxt      = '0;
        bits_nxt       = '0;
        err_nxt        = 1'b0;
        pend_valid_nxt = 1'b0;
        pend_bit_nxt   = 1'b0;
        pend_err_nxt   = 1'b0;
      end
    end else if (s_dur_r > gap_r) begin
      in_frame_nxt   = 1'b0;
      expect_nxt     = 1'b0;
      accum_nxt      = '0;
      bits_nxt       = '0;
      err_nxt        = 1'b0;
      pend_valid_nxt = 1'b0;
      pend_bit_nxt   = 1'b0;
      pend_err_nxt   = 1'b0;
    end else begin
      accum_nxt      = acc_commit;
      bits_nxt       = bits_commit;
      err_nxt        = err_commit;
      pend_valid_nxt = 1'b0;
      pend_bit_nxt   = 1'b0;
      pend_err_nxt   = 1'b0;
      if (!expect_r) begin
        expect_nxt = 1'b1;
      end else begin
        expect_nxt     = 1'b0;
        pend_valid_nxt = 1'b1;
        pend_bit_nxt   = (s_dur_r <= BIT_SPLIT_US);
        pend_err_nxt   = !(!prev_lvl_r && near_nominal(prev_dur_r, SKIP_US, tol_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      prev_lvl_r   <= 1'b0;
      prev_dur_r   <= '0;
      expect_r     <= 1'b0;
      accum_r      <= '0;
      bits_r       <= '0;
      err_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      pend_bit_r   <= 1'b0;
      pend_err_r   <= 1'b0;
    end else if (s_adv) begin
      in_frame_r   <= in_frame_nxt;
      prev_lvl_r   <= prev_lvl_nxt;
      prev_dur_r   <= prev_dur_nxt;
      expect_r     <= expect_nxt;
      accum_r      <= accum_nxt;
      bits_r       <= bits_nxt;
      err_r        <= err_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_bit_r   <= pend_bit_nxt;
      pend_err_r   <= pend_err_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s_adv && s_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv && s_emit) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 48'(result_r);

endmodule

/* rtl/irpfd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse frame decoder checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "ir_pulse_frame_decoder_top_assert.svh"

module irpfd_checker
  import irpfd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  logic [CODE_W-1:0] code_word;
  logic [CNT_W-1:0]  bit_count;
  logic [KEY_W-1:0]  key_index;

  assign code_word = out_tdata[31:0];
  assign bit_count = out_tdata[37:32];
  assign key_index = out_tdata[43:39];

  // Hold a stalled transaction
  `IRPFD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Never show more than a full word of bits
  `IRPFD_ASSERT_SAME(a_count_range, out_tvalid, bit_count <= CNT_W'(CODE_W))

  // Leave bits above the count clear
  `IRPFD_ASSERT_SAME(a_word_clean, out_tvalid, (code_word >> bit_count) == '0)

  // Key index is a table slot or unknown
  `IRPFD_ASSERT_SAME(a_key_range, out_tvalid, key_index <= KEY_UNKNOWN)

  // Drop the result channel on reset
  `IRPFD_ASSERT_ALWAYS(a_reset_idle, !rst_n, !out_tvalid)

endmodule

bind ir_pulse_frame_decoder_top irpfd_checker u_irpfd_checker (.*);

/* verif/ir_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR frame checker
// Watches the pulse, result and register channels of the IR pulse frame
// decoder. Tracks the register writes, decodes every accepted pulse into the
// frame results it must produce, and compares each result transaction field by
// field with the oldest one still owed. Reports counts back to the testbench.
// ----------------------------------------------------------------------------
module ir_frame_checker
  import irpfd_pkg::*;
#(
  parameter int MAX_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,      // [15:0] duration_us
  input  logic        in_tuser,      // [0] level
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,     // [31:0] code_word, [37:32] bit_count,
                                     // [38] skip_error, [43:39] key_index, [47:44] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          frames_waiting,
  output int          frames_predicted,
  output int          frames_checked,
  output int          pulses_seen
);

  bit [11:0] tol_us;
  bit [15:0] gap_us;

  bit        in_frame;
  bit        prev_lvl;
  bit [15:0] prev_dur;
  bit        want_data;
  bit [31:0] word;
  bit [5:0]  frame_bits;
  bit        frame_err;
  bit        pend_v;
  bit        pend_b;
  bit        pend_e;

  result_t expected_frames[$];
  int      mismatch_total;
  int      predicted_total;
  int      checked_total;
  int      pulse_total;

  function automatic int unsigned gap_to(input int unsigned a, input int unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic bit close_to(input int unsigned d, input int unsigned nom);
    return gap_to(d, nom) <= tol_us;
  endfunction

  function automatic logic [KEY_W-1:0] match_key(input bit [31:0] code);
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (KEY_CODES[i] == code) begin
        return KEY_W'(i);
      end
    end
    return KEY_UNKNOWN;
  endfunction

  task automatic clear_frame();
    want_data  = 1'b0;
    word       = '0;
    frame_bits = '0;
    frame_err  = 1'b0;
    pend_v     = 1'b0;
    pend_b     = 1'b0;
    pend_e     = 1'b0;
  endtask

  task automatic commit_bit();
    if (pend_v && frame_bits < MAX_BITS) begin
      word[frame_bits] = pend_b;
      frame_bits++;
      if (pend_e) begin
        frame_err = 1'b1;
      end
    end
    pend_v = 1'b0;
    pend_b = 1'b0;
    pend_e = 1'b0;
  endtask

  task automatic decode_pulse(input bit lvl, input bit [15:0] dur);
    result_t res;
    if (!in_frame) begin
      if (!prev_lvl && lvl && close_to(prev_dur, HDR_LOW_US) && close_to(dur, HDR_HIGH_US)) begin
        in_frame = 1'b1;
        clear_frame();
      end
    end else if (dur > gap_us) begin
      if (lvl) begin
        commit_bit();
      end else begin
        pend_v = 1'b0;
      end
      res.code_word  = word;
      res.bit_count  = frame_bits;
      res.skip_error = frame_err;
      res.key_index  = match_key(word);
      expected_frames.push_back(res);
      predicted_total++;
      in_frame = 1'b0;
      clear_frame();
    end else begin
      commit_bit();
      if (!want_data) begin
        want_data = 1'b1;
      end else begin
        pend_v    = 1'b1;
        pend_b    = gap_to(dur, ONE_US) <= gap_to(dur, ZERO_US);
        pend_e    = !(!prev_lvl && close_to(prev_dur, SKIP_US));
        want_data = 1'b0;
      end
    end
    prev_lvl = lvl;
    prev_dur = dur;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      tol_us   = TOL_RESET;
      gap_us   = GAP_RESET;
      in_frame = 1'b0;
      prev_lvl = 1'b0;
      prev_dur = '0;
      clear_frame();
      expected_frames.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == {REG_TOLERANCE, 2'b00}) begin
          tol_us = cfg_pwdata[11:0];
        end else if (cfg_paddr == {REG_END_GAP, 2'b00}) begin
          gap_us = cfg_pwdata[15:0];
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[43:0];
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, out_tdata);
          mismatch_total++;
        end else begin
          want = expected_frames.pop_front();
          check_field("code_word", want.code_word, got.code_word);
          check_field("bit_count", 32'(want.bit_count), 32'(got.bit_count));
          check_field("skip_error", 32'(want.skip_error), 32'(got.skip_error));
          check_field("key_index", 32'(want.key_index), 32'(got.key_index));
          check_field("padding", '0, 32'(out_tdata[47:44]));
          checked_total++;
        end
      end
      if (in_tvalid && in_tready) begin
        decode_pulse(in_tuser, in_tdata);
        pulse_total++;
      end
    end
    mismatches       <= mismatch_total;
    frames_waiting   <= expected_frames.size();
    frames_predicted <= predicted_total;
    frames_checked   <= checked_total;
    pulses_seen      <= pulse_total;
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse frame decoder testbench
// Drives pulse transactions into the decoder: a short directed set of header,
// skip, bit and frame-end corner cases, then mostly well-formed frames with
// random content mixed with noise, over several register settings and
// sender/receiver throttling modes, including a long output hold-off.
// The checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import irpfd_pkg::*;

  localparam int MAX_BITS    = 32;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;     // [15:0] duration_us
  logic        in_tuser    = 1'b0;   // [0] level
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [47:0] out_tdata;            // [31:0] code_word, [37:32] bit_count,
                                     // [38] skip_error, [43:39] key_index, [47:44] zero
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches;
  int frames_waiting;
  int frames_predicted;
  int frames_checked;
  int pulses_seen;

  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int tol_now     = TOL_RESET;
  int gap_now     = GAP_RESET;
  int pulses_sent = 0;
  bit hold_toggle = 1'b0;
  bit hold_seen   = 1'b0;
  int hold_left   = 0;

  ir_pulse_frame_decoder_top #(.MAX_BITS(MAX_BITS)) uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  ir_frame_checker #(.MAX_BITS(MAX_BITS)) frame_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .mismatches, .frames_waiting, .frames_predicted, .frames_checked, .pulses_seen
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // hold off the output for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen  <= hold_toggle;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99) >= stall_pct;
    end
  end

  function automatic int jitter(input int nom);
    int lo;
    int hi;
    lo = (nom > tol_now) ? nom - tol_now : 0;
    hi = (nom + tol_now > 65535) ? 65535 : nom + tol_now;
    return $urandom_range(hi, lo);
  endfunction

  function automatic int end_duration();
    int span;
    if (gap_now >= 65535) begin
      return 65535;
    end
    if ($urandom_range(1)) begin
      return $urandom_range(65535, gap_now + 1);
    end
    span = gap_now + 1 + $urandom_range(50);
    return (span > 65535) ? 65535 : span;
  endfunction

  task automatic send_pulse(input bit lvl, input int dur);
    in_tvalid <= 1'b1;
    in_tuser  <= lvl;
    in_tdata  <= dur[15:0];
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pulses_sent++;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_bit(input bit value, input bit broken);
    if (!broken) begin
      send_pulse(1'b0, jitter(SKIP_US));
    end else if ($urandom_range(1)) begin
      send_pulse(1'b1, jitter(SKIP_US));
    end else begin
      send_pulse(1'b0, SKIP_US + tol_now + 1 + $urandom_range(400));
    end
    send_pulse($urandom_range(9) != 0,
               value ? $urandom_range(1100, 100) : $urandom_range(2100, 1101));
  endtask

  task automatic send_frame(input logic [31:0] code, input int bits, input int bad_pct,
                            input bit end_lvl);
    send_pulse(1'b0, jitter(HDR_LOW_US));
    send_pulse(1'b1, jitter(HDR_HIGH_US));
    for (int i = 0; i < bits; i++) begin
      send_bit(code[i % 32], $urandom_range(99) < bad_pct);
    end
    send_pulse(end_lvl, end_duration());
  endtask

  task automatic random_burst();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_frame(KEY_CODES[$urandom_range(KEY_COUNT - 1)], 32,
                 ($urandom_range(9) < 7) ? 0 : 5, $urandom_range(3) != 0);
    end else if (pick < 20) begin
      send_frame($urandom, 32 + $urandom_range(2), 8, 1'($urandom_range(1)));
    end else if (pick < 80) begin
      send_frame($urandom, $urandom_range(12), 10, 1'($urandom_range(1)));
    end else begin
      repeat ($urandom_range(6, 1)) begin
        case ($urandom_range(3))
          0: send_pulse(1'($urandom_range(1)), $urandom_range(65535));
          1: send_pulse(1'($urandom_range(1)), jitter(HDR_LOW_US));
          2: send_pulse(1'($urandom_range(1)), jitter(HDR_HIGH_US));
          default: send_pulse(1'($urandom_range(1)), jitter(SKIP_US));
        endcase
      end
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (frames_waiting != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int tol, input int gap, input int send_idle,
                           input int recv_stall, input int goal, input bit hold);
    int start;
    wait_idle();
    cfg_write({REG_TOLERANCE, 2'b00}, tol);
    cfg_write({REG_END_GAP, 2'b00}, gap);
    tol_now   = tol;
    gap_now   = gap;
    idle_pct  = send_idle;
    stall_pct <= recv_stall;
    if (hold) begin
      hold_toggle <= ~hold_toggle;
    end
    start = pulses_sent;
    while (pulses_sent - start < goal) begin
      random_burst();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // header at the tolerance edges (low part short, high part long), then a long low with nothing pending
    send_pulse(1'b0, 8800);
    send_pulse(1'b1, 4700);
    send_pulse(1'b0, 30001);
    // header at the opposite edges; tie bit, low-level data half, high skip dropped by a long low
    send_pulse(1'b0, 9200);
    send_pulse(1'b1, 4300);
    send_pulse(1'b0, 550);
    send_pulse(1'b1, 1100);
    send_pulse(1'b0, 350);
    send_pulse(1'b0, 1101);
    send_pulse(1'b1, 550);
    send_pulse(1'b1, 600);
    send_pulse(1'b0, 65535);
    // near-miss header, then a skip out of tolerance and a zero-length data half
    send_pulse(1'b0, 9201);
    send_pulse(1'b1, 4500);
    send_pulse(1'b0, 9000);
    send_pulse(1'b1, 4500);
    send_pulse(1'b0, 751);
    send_pulse(1'b1, 0);
    send_pulse(1'b1, 30001);
    // unpaired skip ended by a long low
    send_pulse(1'b0, 9000);
    send_pulse(1'b1, 4500);
    send_pulse(1'b0, 550);
    send_pulse(1'b0, 30001);

    run_phase(200,  30000, 0,  0,  65, 1'b0);
    run_phase(0,    30000, 66, 0,  65, 1'b0);
    run_phase(4095, 65535, 0,  66, 65, 1'b0);
    run_phase(4095, 0,     23, 23, 65, 1'b0);
    run_phase(150,  2500,  0,  0,  65, 1'b1);
    run_phase(300,  12000, 66, 0,  65, 1'b0);
    run_phase(75,   65534, 0,  66, 65, 1'b0);
    run_phase(200,  30000, 23, 23, 65, 1'b0);
    wait_idle();

    $display("Covered %0d pulses, %0d predicted and %0d checked frames over 8 settings,",
             pulses_seen, frames_predicted, frames_checked);
    $display("with sender gaps, receiver stalls and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
